>>> design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the i2c master byte engine
// Mode codes, classified item format, engine operation codes, defaults.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // host mode codes on in_mode
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned TPP_W = 10;
  localparam logic [TPP_W-1:0] TPP_RESET = 10'd40;

  localparam logic [4:0] COND_PHASES = 5'd3;
  localparam logic [4:0] BYTE_PHASES = 5'd18;
  localparam logic [4:0] ACK_PHASE   = 5'd16;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_level;
  } item_t;

  // one result beat
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       rejected;
  } result_t;

endpackage

>>> design/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front: input side of the i2c master byte engine
// Accepts input beats and classifies the mode into a command for the queue.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_mode,
  input  logic [7:0]      in_data_byte,
  input  logic            in_send_ack,
  input  logic            in_sda_level,
  input  logic            q_full,
  output logic            q_push,
  output i2cm_pkg::item_t q_item
);

  i2cm_pkg::cmd_t cmd;

  always_comb begin
    unique case (in_mode)
      i2cm_pkg::MODE_START: cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::MODE_STOP:  cmd = i2cm_pkg::CMD_STOP;
      i2cm_pkg::MODE_WRITE: cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::MODE_READ:  cmd = i2cm_pkg::CMD_READ;
      // unused modes behave as a tick
      default:              cmd = i2cm_pkg::CMD_TICK;
    endcase
  end

  assign in_ready         = !q_full;
  assign q_push           = in_valid && !q_full;
  assign q_item.cmd       = cmd;
  assign q_item.data_byte = in_data_byte;
  assign q_item.send_ack  = in_send_ack;
  assign q_item.sda_level = in_sda_level;

endmodule

>>> design/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue: short item queue between front and back
// Small register fifo with one write and one read per cycle.
// ----------------------------------------------------------------------------
module i2cm_queue #(
  parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2cm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output i2cm_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  i2cm_pkg::item_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back: bus engine of the i2c master byte engine
// Runs start, stop, write and read sequences one queued beat at a time and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module i2cm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [i2cm_pkg::TPP_W-1:0]    cfg_wdata,
  input  logic                          q_not_empty,
  input  i2cm_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output i2cm_pkg::result_t             out_res
);

  localparam int unsigned TW = i2cm_pkg::TPP_W;

  logic [TW-1:0]     tpp_r;
  i2cm_pkg::op_t     op_r, op_nxt;
  logic [4:0]        phase_r, phase_nxt;
  logic [TW-1:0]     tick_r, tick_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              ack_choice_r, ack_choice_nxt;
  logic              ack_flag_r, ack_flag_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic [7:0]        read_hold_r, read_hold_nxt;
  logic              out_valid_r;
  i2cm_pkg::result_t res_r, res_nxt;

  logic              done, rej;
  logic [TW-1:0]     limit, tick_inc;
  logic [4:0]        phase_inc, phase_total;
  logic [1:0]        pins;
  i2cm_pkg::op_t     cmd_op;

  // pin levels {scl, sda} for a phase of an operation
  function automatic logic [1:0] phase_pins(i2cm_pkg::op_t op, logic [4:0] p,
                                             logic [7:0] sh, logic ack_c,
                                             logic scl, logic sda);
    logic [1:0] r;
    r = {scl, sda};
    unique case (op)
      i2cm_pkg::OP_START: r = {(p < 5'd2), (p == 5'd0)};
      i2cm_pkg::OP_STOP:  r = {((p != 5'd0) ? 1'b1 : scl), (p == 5'd2)};
      i2cm_pkg::OP_WRITE: r = {p[0], ((p < i2cm_pkg::ACK_PHASE) ? sh[7] : 1'b1)};
      i2cm_pkg::OP_READ:  r = {p[0], ((p < i2cm_pkg::ACK_PHASE) ? 1'b1 : !ack_c)};
      default:            r = {scl, sda};
    endcase
    return r;
  endfunction

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  always_comb begin
    unique case (q_item.cmd)
      i2cm_pkg::CMD_START: cmd_op = i2cm_pkg::OP_START;
      i2cm_pkg::CMD_STOP:  cmd_op = i2cm_pkg::OP_STOP;
      i2cm_pkg::CMD_WRITE: cmd_op = i2cm_pkg::OP_WRITE;
      i2cm_pkg::CMD_READ:  cmd_op = i2cm_pkg::OP_READ;
      default:             cmd_op = i2cm_pkg::OP_IDLE;
    endcase
  end

  always_comb begin
    op_nxt         = op_r;
    phase_nxt      = phase_r;
    tick_nxt       = tick_r;
    shift_nxt      = shift_r;
    ack_choice_nxt = ack_choice_r;
    ack_flag_nxt   = ack_flag_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    read_hold_nxt  = read_hold_r;
    done           = 1'b0;
    rej            = 1'b0;
    pins           = {scl_r, sda_r};
    limit          = (tpp_r == '0) ? TW'(1) : tpp_r;
    tick_inc       = tick_r + TW'(1);
    phase_inc      = phase_r + 5'd1;
    phase_total    = (op_r == i2cm_pkg::OP_START || op_r == i2cm_pkg::OP_STOP) ?
                     i2cm_pkg::COND_PHASES : i2cm_pkg::BYTE_PHASES;

    if (q_item.cmd != i2cm_pkg::CMD_TICK) begin
      if (op_r != i2cm_pkg::OP_IDLE) begin
        rej = 1'b1;
      end else begin
        op_nxt    = cmd_op;
        phase_nxt = '0;
        tick_nxt  = '0;
        if (cmd_op == i2cm_pkg::OP_WRITE) begin
          shift_nxt = q_item.data_byte;
        end
        if (cmd_op == i2cm_pkg::OP_READ) begin
          shift_nxt      = '0;
          ack_choice_nxt = q_item.send_ack;
        end
        pins    = phase_pins(cmd_op, 5'd0, shift_nxt, ack_choice_nxt, scl_r, sda_r);
        scl_nxt = pins[1];
        sda_nxt = pins[0];
      end
    end else if (op_r != i2cm_pkg::OP_IDLE) begin
      if (tick_inc >= limit) begin
        tick_nxt = '0;
        // sample on the end of each scl-high phase
        if (phase_r[0]) begin
          if (op_r == i2cm_pkg::OP_WRITE) begin
            if (phase_r < i2cm_pkg::ACK_PHASE) begin
              shift_nxt = {shift_r[6:0], 1'b0};
            end else begin
              ack_flag_nxt = !q_item.sda_level;
            end
          end else if (op_r == i2cm_pkg::OP_READ) begin
            if (phase_r < i2cm_pkg::ACK_PHASE) begin
              shift_nxt = {shift_r[6:0], q_item.sda_level};
            end else begin
              read_hold_nxt = shift_r;
            end
          end
        end
        if (phase_inc >= phase_total) begin
          if (op_r == i2cm_pkg::OP_START) begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b1;
          end else if (op_r == i2cm_pkg::OP_WRITE || op_r == i2cm_pkg::OP_READ) begin
            scl_nxt = 1'b0;
          end
          op_nxt    = i2cm_pkg::OP_IDLE;
          phase_nxt = '0;
          done      = 1'b1;
        end else begin
          phase_nxt = phase_inc;
          pins      = phase_pins(op_r, phase_inc, shift_nxt, ack_choice_r, scl_r, sda_r);
          scl_nxt   = pins[1];
          sda_nxt   = pins[0];
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end

    res_nxt.scl_out   = scl_nxt;
    res_nxt.sda_out   = sda_nxt;
    res_nxt.busy_res  = (op_nxt != i2cm_pkg::OP_IDLE);
    res_nxt.done_res  = done;
    res_nxt.read_byte = read_hold_nxt;
    res_nxt.ack_seen  = ack_flag_nxt;
    res_nxt.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r        <= i2cm_pkg::TPP_RESET;
      op_r         <= i2cm_pkg::OP_IDLE;
      phase_r      <= '0;
      tick_r       <= '0;
      shift_r      <= '0;
      ack_choice_r <= 1'b0;
      ack_flag_r   <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      read_hold_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        tpp_r <= cfg_wdata;
      end
      if (q_pop) begin
        op_r         <= op_nxt;
        phase_r      <= phase_nxt;
        tick_r       <= tick_nxt;
        shift_r      <= shift_nxt;
        ack_choice_r <= ack_choice_nxt;
        ack_flag_r   <= ack_flag_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        read_hold_r  <= read_hold_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

>>> design/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine: i2c master byte engine, top level
// Host items (ticks and bus commands) in, one status beat out per item.
// ----------------------------------------------------------------------------
// usage:
//   in_* beats carry a mode (tick, start, stop, write byte, read byte), the
//   byte to send, the ack choice for reads and the sampled sda level.
//   every accepted input beat yields exactly one out_* beat with the scl and
//   sda drive levels, busy, done, the last read byte, the last write ack and
//   a rejected flag for a command sent while busy.
//   cfg_we / cfg_wdata set the number of ticks per half-bit phase; write it
//   only while the engine is idle.
//   an accepted input beat is registered first in the front queue and then,
//   as its result beat, in the output register.
//   throughput: one beat per cycle while out_ready is high; the engine updates
//   its phase counters and pin registers once per beat from the queue head.
//   when out_ready is low the result is held, the queue fills, and in_ready
//   drops once all queue entries are taken.
//   reset (rst_n low, synchronous) returns the engine to idle with both
//   lines released, empties the queue and sets ticks per phase to 40.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine #(
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [i2cm_pkg::TPP_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_mode,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_send_ack,
  input  logic                       in_sda_level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_scl_out,
  output logic                       out_sda_out,
  output logic                       out_busy_res,
  output logic                       out_done_res,
  output logic [7:0]                 out_read_byte,
  output logic                       out_ack_seen,
  output logic                       out_rejected
);

  logic              q_full, q_push, q_pop, q_not_empty;
  i2cm_pkg::item_t   push_item, head_item;
  i2cm_pkg::result_t res;

  i2cm_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .in_send_ack  (in_send_ack),
    .in_sda_level (in_sda_level),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (head_item)
  );

  i2cm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (res)
  );

  assign out_scl_out   = res.scl_out;
  assign out_sda_out   = res.sda_out;
  assign out_busy_res  = res.busy_res;
  assign out_done_res  = res.done_res;
  assign out_read_byte = res.read_byte;
  assign out_ack_seen  = res.ack_seen;
  assign out_rejected  = res.rejected;

endmodule

>>> design/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker: port-level checks of the i2c master byte engine
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_scl_out,
  input logic       out_sda_out,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [7:0] out_read_byte,
  input logic       out_ack_seen,
  input logic       out_rejected
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_scl_out, out_sda_out,
      out_busy_res, out_done_res, out_read_byte, out_ack_seen, out_rejected}))
    else $error("result beat changed while stalled");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // a finished command leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while busy");

  // only a busy engine rejects, and a rejected beat never finishes a command
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res && !out_done_res)
    else $error("rejected beat while idle or with done");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_scl_out   (out_scl_out),
  .out_sda_out   (out_sda_out),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_read_byte (out_read_byte),
  .out_ack_seen  (out_ack_seen),
  .out_rejected  (out_rejected)
);

>>> test/tb_i2c_master_byte_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine: regression bench for the i2c master byte engine
// Drives host beats (ticks and bus commands) with bursty valid and a stalling
// result side, predicts every status beat with a local engine model and
// compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;

  localparam int unsigned TW = i2cm_pkg::TPP_W;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;
  localparam logic [TW-1:0] TPP_MAX = 10'd1023;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [TW-1:0] cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [2:0]    in_mode = i2cm_pkg::MODE_TICK;
  logic [7:0]    in_data_byte = '0;
  logic          in_send_ack = 1'b0;
  logic          in_sda_level = 1'b1;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          out_scl_out;
  logic          out_sda_out;
  logic          out_busy_res;
  logic          out_done_res;
  logic [7:0]    out_read_byte;
  logic          out_ack_seen;
  logic          out_rejected;

  i2c_master_byte_engine u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .in_send_ack  (in_send_ack),
    .in_sda_level (in_sda_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_read_byte(out_read_byte),
    .out_ack_seen (out_ack_seen),
    .out_rejected (out_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // engine model state
  i2cm_pkg::op_t  eng_op;
  logic [4:0]     eng_phase;
  logic [TW-1:0]  eng_ticks;
  logic [7:0]     eng_shift;
  logic           eng_ack_sel;
  logic           eng_ack_hit;
  logic           eng_scl;
  logic           eng_sda;
  logic [7:0]     eng_rd_byte;
  logic [TW-1:0]  tpp_model;

  i2cm_pkg::result_t pending_status[$];
  int beats_sent = 0;
  int results_checked = 0;
  int dones_seen = 0;
  int rejects_seen = 0;
  int mismatches = 0;
  int burst_left = 0;
  int hold_req = 0;

  function automatic void reset_engine_model();
    eng_op      = i2cm_pkg::OP_IDLE;
    eng_phase   = '0;
    eng_ticks   = '0;
    eng_shift   = '0;
    eng_ack_sel = 1'b0;
    eng_ack_hit = 1'b0;
    eng_scl     = 1'b1;
    eng_sda     = 1'b1;
    eng_rd_byte = '0;
    tpp_model   = i2cm_pkg::TPP_RESET;
  endfunction

  // pin levels for the current phase of the running command
  function automatic void set_phase_pins();
    case (eng_op)
      i2cm_pkg::OP_START: begin
        eng_scl = (eng_phase < 2);
        eng_sda = (eng_phase == 0);
      end
      i2cm_pkg::OP_STOP: begin
        if (eng_phase != 0) eng_scl = 1'b1;
        eng_sda = (eng_phase == 2);
      end
      i2cm_pkg::OP_WRITE: begin
        eng_scl = eng_phase[0];
        eng_sda = (eng_phase < i2cm_pkg::ACK_PHASE) ? eng_shift[7] : 1'b1;
      end
      i2cm_pkg::OP_READ: begin
        eng_scl = eng_phase[0];
        eng_sda = (eng_phase < i2cm_pkg::ACK_PHASE) ? 1'b1 : !eng_ack_sel;
      end
      default: ;
    endcase
  endfunction

  function automatic i2cm_pkg::result_t predict_status(input logic [2:0] mode,
                                                       input logic [7:0] data,
                                                       input logic sack,
                                                       input logic sda_in);
    i2cm_pkg::result_t r;
    logic [TW-1:0] lim;
    logic [4:0] total;
    logic fin;
    r = '0;
    fin = 1'b0;
    if (mode >= i2cm_pkg::MODE_START && mode <= i2cm_pkg::MODE_READ) begin
      if (eng_op != i2cm_pkg::OP_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        eng_op = i2cm_pkg::op_t'(mode);
        eng_phase = '0;
        eng_ticks = '0;
        if (mode == i2cm_pkg::MODE_WRITE) eng_shift = data;
        if (mode == i2cm_pkg::MODE_READ) begin
          eng_shift = '0;
          eng_ack_sel = sack;
        end
        set_phase_pins();
      end
    end else if (eng_op != i2cm_pkg::OP_IDLE) begin
      // spare modes land here too and count as ticks
      lim = (tpp_model == 0) ? 10'd1 : tpp_model;
      eng_ticks = eng_ticks + 1'b1;
      if (eng_ticks >= lim) begin
        eng_ticks = '0;
        // sda is sampled at the end of each scl-high phase
        if (eng_phase[0]) begin
          if (eng_op == i2cm_pkg::OP_WRITE) begin
            if (eng_phase < i2cm_pkg::ACK_PHASE) eng_shift = eng_shift << 1;
            else eng_ack_hit = !sda_in;
          end else if (eng_op == i2cm_pkg::OP_READ) begin
            if (eng_phase < i2cm_pkg::ACK_PHASE) eng_shift = {eng_shift[6:0], sda_in};
            else eng_rd_byte = eng_shift;
          end
        end
        eng_phase = eng_phase + 1'b1;
        total = (eng_op == i2cm_pkg::OP_START || eng_op == i2cm_pkg::OP_STOP) ?
                i2cm_pkg::COND_PHASES : i2cm_pkg::BYTE_PHASES;
        if (eng_phase >= total) begin
          if (eng_op == i2cm_pkg::OP_START) begin
            eng_scl = 1'b0;
            eng_sda = 1'b1;
          end else if (eng_op == i2cm_pkg::OP_WRITE || eng_op == i2cm_pkg::OP_READ) begin
            eng_scl = 1'b0;
          end
          eng_op = i2cm_pkg::OP_IDLE;
          eng_phase = '0;
          fin = 1'b1;
        end else begin
          set_phase_pins();
        end
      end
    end
    r.scl_out   = eng_scl;
    r.sda_out   = eng_sda;
    r.busy_res  = (eng_op != i2cm_pkg::OP_IDLE);
    r.done_res  = fin;
    r.read_byte = eng_rd_byte;
    r.ack_seen  = eng_ack_hit;
    return r;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_beat(input logic [2:0] mode, input logic [7:0] data,
                           input logic sack, input logic sda_in);
    int gap;
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= data;
    in_send_ack  <= sack;
    in_sda_level <= sda_in;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(predict_status(mode, data, sack, sda_in));
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 12);
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic pick_sda(input int pol);
    if (pol == SDA_LOW) return 1'b0;
    if (pol == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic tick_beat(input int pol);
    logic [2:0] mode;
    mode = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))
                                       : i2cm_pkg::MODE_TICK;
    send_beat(mode, 8'($urandom), 1'($urandom), pick_sda(pol));
  endtask

  // tick until the engine goes idle, now and then slipping in a command
  task automatic finish_cmd(input int pol, input int reject_pct);
    while (eng_op != i2cm_pkg::OP_IDLE) begin
      if ($urandom_range(0, 99) < reject_pct)
        send_beat(3'($urandom_range(i2cm_pkg::MODE_START, i2cm_pkg::MODE_READ)),
                  8'($urandom), 1'($urandom), 1'($urandom));
      else
        tick_beat(pol);
    end
  endtask

  task automatic run_cmd(input logic [2:0] mode, input logic [7:0] data, input logic sack,
                         input int pol, input int reject_pct);
    send_beat(mode, data, sack, 1'($urandom));
    finish_cmd(pol, reject_pct);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic set_phase_ticks(input logic [TW-1:0] v);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    tpp_model = v;
    cfg_we <= 1'b0;
  endtask

  task automatic run_transfer();
    int n;
    run_cmd(i2cm_pkg::MODE_START, 8'($urandom), 1'($urandom), SDA_RAND, 3);
    run_cmd(i2cm_pkg::MODE_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, 3);
    n = $urandom_range(1, 3);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        run_cmd(i2cm_pkg::MODE_START, 8'($urandom), 1'($urandom), SDA_RAND, 3);
      if ($urandom_range(0, 1) == 0)
        run_cmd(i2cm_pkg::MODE_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, 3);
      else
        run_cmd(i2cm_pkg::MODE_READ, 8'($urandom), 1'($urandom), SDA_RAND, 3);
    end
    run_cmd(i2cm_pkg::MODE_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 3);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 8))
      send_beat(3'($urandom_range(i2cm_pkg::MODE_TICK, MODE_SPARE_HI)), 8'($urandom),
                1'($urandom), 1'($urandom));
    finish_cmd(SDA_RAND, 0);
  endtask

  // ------------------------------------------------------------ receiver
  always @(posedge clk) begin : result_side
    int hold_left;
    int rx_left;
    int rx_style;
    logic [7:0] rx_pat;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      if (rx_left <= 0) begin
        rx_style = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 120);
        rx_pat = 8'($urandom_range(1, 255));
      end
      rx_left--;
      case (rx_style)
        0: out_ready <= 1'b1;
        1: begin
          out_ready <= rx_pat[0];
          rx_pat = {rx_pat[0], rx_pat[7:1]};
        end
        default: out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic log_error(input string why, input i2cm_pkg::result_t want,
                           input i2cm_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s exp scl=%b sda=%b busy=%b done=%b rd=%02h ack=%b rej=%b",
               $realtime, why, want.scl_out, want.sda_out, want.busy_res, want.done_res,
               want.read_byte, want.ack_seen, want.rejected);
      $display("%0t: %s got scl=%b sda=%b busy=%b done=%b rd=%02h ack=%b rej=%b",
               $realtime, why, got.scl_out, got.sda_out, got.busy_res, got.done_res,
               got.read_byte, got.ack_seen, got.rejected);
    end
  endtask

  always @(posedge clk) begin : check_results
    i2cm_pkg::result_t got;
    i2cm_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_scl_out, out_sda_out, out_busy_res, out_done_res, out_read_byte,
             out_ack_seen, out_rejected};
      if (pending_status.size() == 0) begin
        log_error("unexpected beat", '0, got);
      end else begin
        want = pending_status.pop_front();
        if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
            got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
            got.read_byte !== want.read_byte || got.ack_seen !== want.ack_seen ||
            got.rejected !== want.rejected)
          log_error("status mismatch", want, got);
        results_checked++;
        if (want.done_res) dones_seen++;
        if (want.rejected) rejects_seen++;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_default_rate();
    // idle ticks change nothing, then one start at the reset phase length
    tick_beat(SDA_RAND);
    send_beat(MODE_SPARE_LO, 8'hFF, 1'b1, 1'b0);
    send_beat(MODE_SPARE_HI, 8'h00, 1'b0, 1'b1);
    run_cmd(i2cm_pkg::MODE_START, 8'h00, 1'b0, SDA_RAND, 0);
  endtask

  task automatic test_bus_ops();
    // zero phase length behaves as one
    set_phase_ticks('0);
    run_cmd(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, SDA_RAND, 0);
    run_cmd(i2cm_pkg::MODE_START, 8'hA5, 1'b1, SDA_RAND, 0);
    run_cmd(i2cm_pkg::MODE_WRITE, 8'hFF, 1'b0, SDA_LOW, 0);
    run_cmd(i2cm_pkg::MODE_WRITE, 8'h00, 1'b1, SDA_HIGH, 0);
    run_cmd(i2cm_pkg::MODE_READ, 8'h3C, 1'b1, SDA_HIGH, 0);
    send_beat(i2cm_pkg::MODE_READ, 8'hFF, 1'b0, 1'b0);
    // every command while busy is turned away
    send_beat(i2cm_pkg::MODE_START, 8'h00, 1'b1, 1'b1);
    send_beat(i2cm_pkg::MODE_STOP, 8'hFF, 1'b0, 1'b0);
    send_beat(i2cm_pkg::MODE_WRITE, 8'h81, 1'b1, 1'b1);
    send_beat(i2cm_pkg::MODE_READ, 8'h7E, 1'b1, 1'b0);
    finish_cmd(SDA_LOW, 0);
    run_cmd(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, SDA_RAND, 0);
    tick_beat(SDA_RAND);
  endtask

  task automatic test_rate_lowered_mid_phase();
    set_phase_ticks(TPP_MAX);
    send_beat(i2cm_pkg::MODE_START, 8'h00, 1'b0, 1'b1);
    repeat (6) tick_beat(SDA_RAND);
    // tick count already past the new length, phase ends on the next tick
    set_phase_ticks(10'd2);
    finish_cmd(SDA_RAND, 0);
    run_cmd(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, SDA_RAND, 0);
  endtask

  task automatic test_output_stall();
    set_phase_ticks(10'd1);
    hold_req = 300;
    run_transfer();
  endtask

  task automatic test_sender_pause();
    run_cmd(i2cm_pkg::MODE_START, 8'($urandom), 1'b0, SDA_RAND, 0);
    send_beat(i2cm_pkg::MODE_WRITE, 8'($urandom), 1'b0, 1'b0);
    repeat (7) tick_beat(SDA_RAND);
    wait_drain();
    finish_cmd(SDA_RAND, 5);
    wait_drain();
    run_cmd(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, SDA_RAND, 0);
  endtask

  task automatic test_random_traffic();
    logic [TW-1:0] plan [8];
    int phase_end;
    int pick;
    plan = '{10'd1, 10'd2, 10'd1, 10'd3, 10'd1, 10'd5, 10'd2, 10'd1};
    foreach (plan[i]) begin
      set_phase_ticks(plan[i]);
      phase_end = beats_sent + 100;
      while (beats_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) run_transfer();
        else if (pick == 8) run_noise();
        else repeat ($urandom_range(1, 6)) tick_beat(SDA_RAND);
      end
    end
  endtask

  initial begin
    reset_engine_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_rate();
    test_bus_ops();
    test_rate_lowered_mid_phase();
    test_output_stall();
    test_sender_pause();
    test_random_traffic();
    wait_drain();
    repeat (10) @(posedge clk);
    $display("covered %0d beats, %0d status results checked", beats_sent, results_checked);
    $display("commands completed %0d, commands turned away while busy %0d",
             dones_seen, rejects_seen);
    if (mismatches == 0) begin
      $display("i2c_master_byte_engine regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("i2c_master_byte_engine regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("watchdog expired with %0d results outstanding", pending_status.size());
    $display("i2c_master_byte_engine regression: fail");
    $finish;
  end

endmodule

>>> sim.f
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_queue.sv
design/i2cm_back.sv
design/i2c_master_byte_engine.sv
design/i2cm_checker.sv
test/tb_i2c_master_byte_engine.sv
